// File: rtl/lcg_pkg.sv
`default_nettype none

package lcg_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIST_BITS  = COORD_BITS + 1;
   localparam int CHAN_BITS  = 8;
   localparam int CHAN_COUNT = 3;
   localparam int COLOR_BITS = CHAN_BITS * CHAN_COUNT;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int PROD_BITS  = CHAN_BITS + FRAC_W;

   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic                  color_match;
      logic [DIST_BITS-1:0]  num;
      logic [DIST_BITS-1:0]  den;
      logic [COLOR_BITS-1:0] start_color;
      logic [COLOR_BITS-1:0] end_color;
   } dist_beat_type;

   typedef struct packed {
      logic                  force_f;
      logic                  force_one;
      logic [DIST_BITS-1:0]  rem;
      logic [DIST_BITS-1:0]  den;
      logic [FRAC_BITS-1:0]  quo;
      logic [COLOR_BITS-1:0] start_color;
      logic [COLOR_BITS-1:0] end_color;
   } div_beat_type;

endpackage

`default_nettype wire

// File: rtl/lcg_front.sv
`default_nettype none

module lcg_front (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      up_valid,
   output logic                                     up_stall,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     cur_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     cur_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0]     cur_color,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     start_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     start_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0]     start_color,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     end_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0]     end_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0]     end_color,
   output logic                                     dn_valid,
   output lcg_pkg::div_beat_type                    dn_beat,
   input  wire                                      dn_stall
);

   localparam int DB = lcg_pkg::DIST_BITS;

   logic                    a_valid_ff;
   lcg_pkg::dist_beat_type  a_beat_ff;
   lcg_pkg::dist_beat_type  a_beat_in;
   logic                    a_stall;
   logic                    b_valid_ff;
   lcg_pkg::div_beat_type   b_beat_ff;
   lcg_pkg::div_beat_type   b_beat_in;

   logic signed [DB-1:0] dx_end;
   logic signed [DB-1:0] dy_end;
   logic signed [DB-1:0] dx_cur;
   logic signed [DB-1:0] dy_cur;
   logic                 num_neg;
   logic                 den_neg;
   logic [DB-1:0]        abs_num;
   logic [DB-1:0]        abs_den;

   always_comb begin
      dx_end = DB'(end_x) - DB'(start_x);
      dy_end = DB'(end_y) - DB'(start_y);
      dx_cur = DB'(cur_x) - DB'(start_x);
      dy_cur = DB'(cur_y) - DB'(start_y);
      a_beat_in.color_match = (cur_color == end_color);
      a_beat_in.start_color = start_color;
      a_beat_in.end_color   = end_color;
      if (dx_end > dy_end) begin
         a_beat_in.num = dx_cur;
         a_beat_in.den = dx_end;
      end else begin
         a_beat_in.num = dy_cur;
         a_beat_in.den = dy_end;
      end
   end

   always_comb begin
      num_neg = a_beat_ff.num[DB-1];
      den_neg = a_beat_ff.den[DB-1];
      abs_num = num_neg ? DB'(~a_beat_ff.num + 1'b1) : a_beat_ff.num;
      abs_den = den_neg ? DB'(~a_beat_ff.den + 1'b1) : a_beat_ff.den;
      b_beat_in.rem         = abs_num;
      b_beat_in.den         = abs_den;
      b_beat_in.quo         = '0;
      b_beat_in.start_color = a_beat_ff.start_color;
      b_beat_in.end_color   = a_beat_ff.end_color;
      if (a_beat_ff.color_match || (abs_den == '0)) begin
         b_beat_in.force_f   = 1'b1;
         b_beat_in.force_one = 1'b1;
      end else if ((abs_num == '0) || (num_neg != den_neg)) begin
         b_beat_in.force_f   = 1'b1;
         b_beat_in.force_one = 1'b0;
      end else if (abs_num >= abs_den) begin
         b_beat_in.force_f   = 1'b1;
         b_beat_in.force_one = 1'b1;
      end else begin
         b_beat_in.force_f   = 1'b0;
         b_beat_in.force_one = 1'b0;
      end
   end

   assign a_stall  = b_valid_ff && dn_stall;
   assign up_stall = a_valid_ff && a_stall;
   assign dn_valid = b_valid_ff;
   assign dn_beat  = b_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (!up_stall) begin
            a_valid_ff <= up_valid;
         end
         if (!a_stall) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         a_beat_ff <= a_beat_in;
      end
      if (!a_stall) begin
         b_beat_ff <= b_beat_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lcg_div_step.sv
`default_nettype none

module lcg_div_step (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         up_valid,
   output logic                        up_stall,
   input  wire lcg_pkg::div_beat_type  up_beat,
   output logic                        dn_valid,
   output lcg_pkg::div_beat_type       dn_beat,
   input  wire                         dn_stall
);

   localparam int DB = lcg_pkg::DIST_BITS;
   localparam int FB = lcg_pkg::FRAC_BITS;

   logic                   valid_ff;
   lcg_pkg::div_beat_type  beat_ff;
   lcg_pkg::div_beat_type  beat_in;
   logic [DB:0]            rem_shift;
   logic [DB:0]            rem_diff;
   logic                   take;

   always_comb begin
      rem_shift = {up_beat.rem, 1'b0};
      rem_diff  = rem_shift - {1'b0, up_beat.den};
      take      = (rem_shift >= {1'b0, up_beat.den});
      beat_in     = up_beat;
      beat_in.rem = take ? rem_diff[DB-1:0] : rem_shift[DB-1:0];
      beat_in.quo = {up_beat.quo[FB-2:0], take};
   end

   assign up_stall = valid_ff && dn_stall;
   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         beat_ff <= beat_in;
      end
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !beat_ff.force_f) |-> (beat_ff.rem < beat_ff.den))
      else $error("remainder not below divisor");

endmodule

`default_nettype wire

// File: rtl/lcg_blend.sv
`default_nettype none

module lcg_blend (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 up_valid,
   output logic                                up_stall,
   input  wire lcg_pkg::div_beat_type          up_beat,
   output logic                                dn_valid,
   output logic [lcg_pkg::COLOR_BITS-1:0]      dn_color,
   input  wire                                 dn_stall
);

   localparam int CB = lcg_pkg::CHAN_BITS;
   localparam int CN = lcg_pkg::CHAN_COUNT;
   localparam int FW = lcg_pkg::FRAC_W;
   localparam int FB = lcg_pkg::FRAC_BITS;
   localparam int PB = lcg_pkg::PROD_BITS;

   logic [FW-1:0] frac;
   logic [FW-1:0] frac_inv;
   logic [PB-1:0] prod_s_in [CN];
   logic [PB-1:0] prod_e_in [CN];
   logic [PB-1:0] prod_s_ff [CN];
   logic [PB-1:0] prod_e_ff [CN];
   logic [PB-1:0] sum      [CN];
   logic [lcg_pkg::COLOR_BITS-1:0] color_in;
   logic [lcg_pkg::COLOR_BITS-1:0] color_ff;
   logic          m_valid_ff;
   logic          m_stall;
   logic          o_valid_ff;

   always_comb begin
      if (up_beat.force_f) begin
         frac = up_beat.force_one ? lcg_pkg::FRAC_ONE : '0;
      end else begin
         frac = {1'b0, up_beat.quo};
      end
      frac_inv = lcg_pkg::FRAC_ONE - frac;
      for (int c = 0; c < CN; c++) begin
         prod_s_in[c] = PB'(up_beat.start_color[c*CB +: CB]) * PB'(frac_inv);
         prod_e_in[c] = PB'(up_beat.end_color[c*CB +: CB]) * PB'(frac);
      end
   end

   always_comb begin
      for (int c = 0; c < CN; c++) begin
         sum[c] = prod_s_ff[c] + prod_e_ff[c];
         color_in[c*CB +: CB] = sum[c][FB +: CB];
      end
   end

   assign m_stall  = o_valid_ff && dn_stall;
   assign up_stall = m_valid_ff && m_stall;
   assign dn_valid = o_valid_ff;
   assign dn_color = color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (!up_stall) begin
            m_valid_ff <= up_valid;
         end
         if (!m_stall) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         prod_s_ff <= prod_s_in;
         prod_e_ff <= prod_e_in;
      end
      if (!m_stall) begin
         color_ff <= color_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/line_color_gradient.sv
// line_color_gradient: color of one point on a line, blended between the
// colors of the line's two endpoints.
// Input channel (req_): one beat carries the current point, the start point
// and the end point, each with signed coordinates and an RGB888 color.
// A beat is taken at a rising edge with req_valid high and req_stall low.
// Result channel (rsp_): one beat per input beat, in order, carrying
// rsp_pixel_color; taken at an edge with rsp_valid high and rsp_stall low.
// Path: 2 front stages, one divider stage per fraction bit, a multiply
// stage and the output register, from input beat to rsp_valid.
// Throughput: one beat per cycle unless stalled; the divider retires one
// quotient bit per stage, so its depth sets the latency and not the rate.
// Stall: every stage holds its beat only while the one after it is full and
// held, so bubbles close up; req_stall rises only when the whole pipe is
// full and rsp_stall is high. A held rsp beat does not change.
// Reset: synchronous, active high; clears all stage valid bits, nothing
// else to prepare, beats are taken in the cycle after reset drops.
`default_nettype none

module line_color_gradient (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_cur_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_cur_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0] req_cur_color,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_start_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_start_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0] req_start_color,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_end_x,
   input  wire signed [lcg_pkg::COORD_BITS-1:0] req_end_y,
   input  wire        [lcg_pkg::COLOR_BITS-1:0] req_end_color,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic       [lcg_pkg::COLOR_BITS-1:0] rsp_pixel_color
);

   localparam int FB = lcg_pkg::FRAC_BITS;

   logic                  div_valid [FB+1];
   logic                  div_stall [FB+1];
   lcg_pkg::div_beat_type div_beat  [FB+1];

   lcg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_valid),
      .up_stall    (req_stall),
      .cur_x       (req_cur_x),
      .cur_y       (req_cur_y),
      .cur_color   (req_cur_color),
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .start_color (req_start_color),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .end_color   (req_end_color),
      .dn_valid    (div_valid[0]),
      .dn_beat     (div_beat[0]),
      .dn_stall    (div_stall[0])
   );

   for (genvar k = 0; k < FB; k++) begin : g_div
      lcg_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[k]),
         .up_stall (div_stall[k]),
         .up_beat  (div_beat[k]),
         .dn_valid (div_valid[k+1]),
         .dn_beat  (div_beat[k+1]),
         .dn_stall (div_stall[k+1])
      );
   end

   lcg_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .up_valid (div_valid[FB]),
      .up_stall (div_stall[FB]),
      .up_beat  (div_beat[FB]),
      .dn_valid (rsp_valid),
      .dn_color (rsp_pixel_color),
      .dn_stall (rsp_stall)
   );

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input held while result side is free");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_front_moves_when_free: assert property (@(posedge clock) disable iff (reset)
      (div_valid[0] && !div_stall[0]) |=> div_valid[1])
      else $error("beat lost between front and divider");

endmodule

`default_nettype wire
